// File: rtl/sqwsw_pkg.sv
// Shared constants, types and helper functions for the square-wave channel.
`timescale 1ns / 1ps

package sqwsw_pkg;

  // operation codes carried by an input word
  localparam logic [2:0] FUNC_READ     = 3'd0;
  localparam logic [2:0] FUNC_WRITE    = 3'd1;
  localparam logic [2:0] FUNC_TIMER    = 3'd2;
  localparam logic [2:0] FUNC_LENGTH   = 3'd3;
  localparam logic [2:0] FUNC_ENVELOPE = 3'd4;
  localparam logic [2:0] FUNC_SWEEP    = 3'd5;
  localparam logic [2:0] FUNC_CLEAR    = 3'd6;

  // register map
  localparam logic [15:0] ADDR_SWEEP   = 16'hFF10;
  localparam logic [15:0] ADDR_LEN_DTY = 16'hFF11;
  localparam logic [15:0] ADDR_ENV     = 16'hFF12;
  localparam logic [15:0] ADDR_PER_LO  = 16'hFF13;
  localparam logic [15:0] ADDR_PER_HI  = 16'hFF14;

  localparam logic [7:0] READ_IDLE = 8'hFF;
  localparam logic [6:0] LEN_FULL  = 7'd64;

  typedef logic [2:0] func_t;

  // duty waveform, stepped MSB first
  function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
    logic [7:0] pat;
    unique case (sel)
      2'd0: pat = 8'b0000_0001;
      2'd1: pat = 8'b1000_0001;
      2'd2: pat = 8'b1000_0111;
      2'd3: pat = 8'b0111_1110;
      default: pat = 8'b0000_0000;
    endcase
    return pat;
  endfunction

  // frequency timer reload: (2048 - period) * 4
  function automatic logic [13:0] timer_reload(input logic [10:0] period);
    logic [11:0] diff;
    diff = 12'd2048 - {1'b0, period};
    return {diff, 2'b00};
  endfunction

  // one sweep calculation; bit 11 flags a result past 2047
  function automatic logic [11:0] sweep_calc(input logic [10:0] shadow,
                                             input logic [2:0]  shift,
                                             input logic        negate);
    logic [10:0] delta;
    delta = shadow >> shift;
    return negate ? ({1'b0, shadow} - {1'b0, delta})
                  : ({1'b0, shadow} + {1'b0, delta});
  endfunction

endpackage

// File: rtl/sqwsw_in_if.sv
// Input channel interface: operation word with valid/ready handshake.
`timescale 1ns / 1ps

interface sqwsw_in_if;
  logic                valid;
  logic                ready;
  sqwsw_pkg::func_t    func;
  logic [15:0]         address;
  logic [7:0]          write_data;

  modport source (output valid, func, address, write_data, input ready);
  modport sink   (input valid, func, address, write_data, output ready);
endinterface

// File: rtl/sqwsw_out_if.sv
// Result channel interface: read data, sample and active flag with valid/ready.
`timescale 1ns / 1ps

interface sqwsw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [3:0]  sample;
  logic        channel_on;

  modport source (output valid, read_data, sample, channel_on, input ready);
  modport sink   (input valid, read_data, sample, channel_on, output ready);
endinterface

// File: rtl/square_wave_channel_with_sweep.sv
// Square-wave sound channel with frequency sweep, length, envelope and duty.
`timescale 1ns / 1ps
//
//  channel   dir  handshake       word contents
//  -------   ---  --------------  ------------------------------------------
//  in_ch     in   valid/ready     func (3), address (16), write_data (8)
//  out_ch    out  valid/ready     read_data (8), sample (4), channel_on (1)
//
//  One word in, one word out. Each accepted word updates the channel state in
//  the same edge and loads the result register, from which the result is
//  presented in the following cycle. A new word is taken every cycle while the
//  result register is empty or being drained, so throughput is one word per clock.
//  rst_n is synchronous, active low, and clears all channel state.
//  A stalled out_ch holds its word and blocks in_ch until it is taken.

module square_wave_channel_with_sweep (
  input  logic              clk,
  input  logic              rst_n,
  sqwsw_in_if.sink          in_ch,
  sqwsw_out_if.source       out_ch
);

  // register file
  logic [7:0]  sweep_reg_r,       sweep_reg_nxt;
  logic [7:0]  len_duty_reg_r,    len_duty_reg_nxt;
  logic [7:0]  env_reg_r,         env_reg_nxt;
  logic [7:0]  per_lo_reg_r,      per_lo_reg_nxt;
  logic [7:0]  per_hi_reg_r,      per_hi_reg_nxt;

  // channel counters
  logic        active_r,          active_nxt;
  logic [13:0] freq_timer_r,      freq_timer_nxt;
  logic [6:0]  length_cnt_r,      length_cnt_nxt;
  logic [2:0]  env_cnt_r,         env_cnt_nxt;
  logic [3:0]  volume_r,          volume_nxt;
  logic [10:0] period_r,          period_nxt;
  logic [10:0] shadow_r,          shadow_nxt;
  logic [3:0]  sweep_cnt_r,       sweep_cnt_nxt;
  logic        sweep_on_r,        sweep_on_nxt;
  logic [2:0]  duty_step_r,       duty_step_nxt;

  // result register
  logic        out_valid_r;
  logic [7:0]  read_data_r,       read_data_nxt;
  logic [3:0]  sample_r,          sample_nxt;
  logic        chan_on_r;

  logic        accept;

  // take a new word whenever the result slot frees up this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = read_data_r;
  assign out_ch.sample     = sample_r;
  assign out_ch.channel_on = chan_on_r;

  // Next-state logic: one operation per word, all paths are short counter
  // updates. The sweep tick chains two 12-bit shift-and-add steps.
  always_comb begin
    logic [2:0]  sp;
    logic [13:0] ft_dec;
    logic [6:0]  len_dec;
    logic [2:0]  env_dec;
    logic [3:0]  sw_dec;
    logic [11:0] calc1;
    logic [11:0] calc2;
    logic [10:0] trig_period;
    logic [7:0]  pat;

    sweep_reg_nxt    = sweep_reg_r;
    len_duty_reg_nxt = len_duty_reg_r;
    env_reg_nxt      = env_reg_r;
    per_lo_reg_nxt   = per_lo_reg_r;
    per_hi_reg_nxt   = per_hi_reg_r;
    active_nxt       = active_r;
    freq_timer_nxt   = freq_timer_r;
    length_cnt_nxt   = length_cnt_r;
    env_cnt_nxt      = env_cnt_r;
    volume_nxt       = volume_r;
    period_nxt       = period_r;
    shadow_nxt       = shadow_r;
    sweep_cnt_nxt    = sweep_cnt_r;
    sweep_on_nxt     = sweep_on_r;
    duty_step_nxt    = duty_step_r;
    read_data_nxt    = sqwsw_pkg::READ_IDLE;

    sp          = sweep_reg_r[6:4];
    ft_dec      = freq_timer_r - 14'd1;
    len_dec     = length_cnt_r - 7'd1;
    env_dec     = env_cnt_r - 3'd1;
    sw_dec      = sweep_cnt_r - 4'd1;
    calc1       = sqwsw_pkg::sweep_calc(shadow_r, sweep_reg_r[2:0], sweep_reg_r[3]);
    calc2       = sqwsw_pkg::sweep_calc(calc1[10:0], sweep_reg_r[2:0], sweep_reg_r[3]);
    trig_period = {in_ch.write_data[2:0], per_lo_reg_r};

    unique case (in_ch.func)
      sqwsw_pkg::FUNC_READ: begin
        unique case (in_ch.address)
          sqwsw_pkg::ADDR_SWEEP:   read_data_nxt = sweep_reg_r | 8'h80;
          sqwsw_pkg::ADDR_LEN_DTY: read_data_nxt = len_duty_reg_r | 8'h3F;
          sqwsw_pkg::ADDR_ENV:     read_data_nxt = env_reg_r;
          sqwsw_pkg::ADDR_PER_HI:  read_data_nxt = per_hi_reg_r | 8'hBF;
          default:                 read_data_nxt = sqwsw_pkg::READ_IDLE;
        endcase
      end
      sqwsw_pkg::FUNC_WRITE: begin
        unique case (in_ch.address)
          sqwsw_pkg::ADDR_SWEEP: sweep_reg_nxt = in_ch.write_data;
          sqwsw_pkg::ADDR_LEN_DTY: begin
            len_duty_reg_nxt = in_ch.write_data;
            length_cnt_nxt   = sqwsw_pkg::LEN_FULL - {1'b0, in_ch.write_data[5:0]};
          end
          sqwsw_pkg::ADDR_ENV: begin
            env_reg_nxt = in_ch.write_data;
            // DAC off kills the channel
            if (in_ch.write_data[7:3] == 5'd0) begin
              active_nxt = 1'b0;
            end
          end
          sqwsw_pkg::ADDR_PER_LO: per_lo_reg_nxt = in_ch.write_data;
          sqwsw_pkg::ADDR_PER_HI: begin
            per_hi_reg_nxt = in_ch.write_data;
            // trigger: reload the counters (length only if empty) and arm the sweep
            if (in_ch.write_data[7]) begin
              if (env_reg_r[7:3] != 5'd0) begin
                active_nxt = 1'b1;
              end
              if (length_cnt_r == 7'd0) begin
                length_cnt_nxt = sqwsw_pkg::LEN_FULL;
              end
              env_cnt_nxt    = env_reg_r[2:0];
              volume_nxt     = env_reg_r[7:4];
              period_nxt     = trig_period;
              shadow_nxt     = trig_period;
              sweep_cnt_nxt  = (sp == 3'd0) ? 4'd8 : {1'b0, sp};
              sweep_on_nxt   = (sp != 3'd0) || (sweep_reg_r[2:0] != 3'd0);
              freq_timer_nxt = sqwsw_pkg::timer_reload(trig_period);
            end
          end
          default: ;
        endcase
      end
      sqwsw_pkg::FUNC_TIMER: begin
        // idle until the first trigger loads the timer
        if (freq_timer_r != 14'd0) begin
          if (ft_dec == 14'd0) begin
            freq_timer_nxt = sqwsw_pkg::timer_reload(period_r);
            duty_step_nxt  = duty_step_r + 3'd1;
          end else begin
            freq_timer_nxt = ft_dec;
          end
        end
      end
      sqwsw_pkg::FUNC_LENGTH: begin
        if (per_hi_reg_r[6] && length_cnt_r != 7'd0) begin
          length_cnt_nxt = len_dec;
          if (len_dec == 7'd0) begin
            active_nxt = 1'b0;
          end
        end
      end
      sqwsw_pkg::FUNC_ENVELOPE: begin
        if (env_reg_r[2:0] != 3'd0 && env_cnt_r != 3'd0) begin
          if (env_dec == 3'd0) begin
            env_cnt_nxt = env_reg_r[2:0];
            // step volume, saturate at both ends
            if (env_reg_r[3]) begin
              if (volume_r != 4'd15) begin
                volume_nxt = volume_r + 4'd1;
              end
            end else begin
              if (volume_r != 4'd0) begin
                volume_nxt = volume_r - 4'd1;
              end
            end
          end else begin
            env_cnt_nxt = env_dec;
          end
        end
      end
      sqwsw_pkg::FUNC_SWEEP: begin
        if (sweep_cnt_r != 4'd0) begin
          if (sw_dec == 4'd0) begin
            sweep_cnt_nxt = (sp == 3'd0) ? 4'd8 : {1'b0, sp};
            if (sweep_on_r && sp != 3'd0) begin
              if (calc1[11]) begin
                active_nxt = 1'b0;
              end else if (sweep_reg_r[2:0] != 3'd0) begin
                // accept the new period, then run the overflow check again
                shadow_nxt = calc1[10:0];
                period_nxt = calc1[10:0];
                if (calc2[11]) begin
                  active_nxt = 1'b0;
                end
              end
            end
          end else begin
            sweep_cnt_nxt = sw_dec;
          end
        end
      end
      sqwsw_pkg::FUNC_CLEAR: begin
        sweep_reg_nxt    = '0;
        len_duty_reg_nxt = '0;
        env_reg_nxt      = '0;
        per_lo_reg_nxt   = '0;
        per_hi_reg_nxt   = '0;
        active_nxt       = 1'b0;
        freq_timer_nxt   = '0;
        length_cnt_nxt   = '0;
        env_cnt_nxt      = '0;
        volume_nxt       = '0;
        period_nxt       = '0;
        shadow_nxt       = '0;
        sweep_cnt_nxt    = '0;
        sweep_on_nxt     = 1'b0;
        duty_step_nxt    = '0;
      end
      default: ;
    endcase

    // sample reflects the state after this word
    pat        = sqwsw_pkg::duty_pattern(len_duty_reg_nxt[7:6]);
    sample_nxt = 4'd0;
    if (active_nxt && env_reg_nxt[7:3] != 5'd0 && pat[~duty_step_nxt]) begin
      sample_nxt = volume_nxt;
    end
  end

  // channel state: advance only on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_reg_r    <= '0;
      len_duty_reg_r <= '0;
      env_reg_r      <= '0;
      per_lo_reg_r   <= '0;
      per_hi_reg_r   <= '0;
      active_r       <= 1'b0;
      freq_timer_r   <= '0;
      length_cnt_r   <= '0;
      env_cnt_r      <= '0;
      volume_r       <= '0;
      period_r       <= '0;
      shadow_r       <= '0;
      sweep_cnt_r    <= '0;
      sweep_on_r     <= 1'b0;
      duty_step_r    <= '0;
    end else if (accept) begin
      sweep_reg_r    <= sweep_reg_nxt;
      len_duty_reg_r <= len_duty_reg_nxt;
      env_reg_r      <= env_reg_nxt;
      per_lo_reg_r   <= per_lo_reg_nxt;
      per_hi_reg_r   <= per_hi_reg_nxt;
      active_r       <= active_nxt;
      freq_timer_r   <= freq_timer_nxt;
      length_cnt_r   <= length_cnt_nxt;
      env_cnt_r      <= env_cnt_nxt;
      volume_r       <= volume_nxt;
      period_r       <= period_nxt;
      shadow_r       <= shadow_nxt;
      sweep_cnt_r    <= sweep_cnt_nxt;
      sweep_on_r     <= sweep_on_nxt;
      duty_step_r    <= duty_step_nxt;
    end
  end

  // result register: load on accept, drop the word once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data_r <= read_data_nxt;
      sample_r    <= sample_nxt;
      chan_on_r   <= active_nxt;
    end
  end

  // an active channel always has its DAC on
  a_active_dac: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (env_reg_r[7:3] != 5'd0))
    else $error("channel active with DAC off");

  // a silent channel produces no sample
  a_off_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !chan_on_r) |-> (sample_r == 4'd0))
    else $error("sample nonzero while channel off");

  // anything but a read returns idle read data
  a_nonread_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.func != sqwsw_pkg::FUNC_READ)
      |=> (read_data_r == sqwsw_pkg::READ_IDLE))
    else $error("non-read word returned read data");

  // clear silences the channel and resets the counters
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.func == sqwsw_pkg::FUNC_CLEAR)
      |=> (!active_r && volume_r == 4'd0 && freq_timer_r == 14'd0 && !chan_on_r))
    else $error("clear left state behind");

  // the result and state reflect the channel flag together
  a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (chan_on_r == active_r))
    else $error("result flag disagrees with channel state");

endmodule

// File: dv/square_wave_channel_with_sweep_tb.sv
// Self-checking bench for the square-wave channel: directed cases, then random traffic.
`timescale 1ns / 1ps

module square_wave_channel_with_sweep_tb;

  // func code 7 is left unused by the block
  localparam sqwsw_pkg::func_t FUNC_UNUSED = 3'd7;

  // idle cycles in a row with no word moving on either side
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_WORDS = 1300;

  // duty waveforms, played MSB first
  localparam logic [7:0] DUTY_WAVES [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] sample;
    logic       channel_on;
  } chan_word_t;

  logic clk;
  logic rst_n;

  sqwsw_in_if  in_ch ();
  sqwsw_out_if out_ch ();

  square_wave_channel_with_sweep uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // --------------------------------------------------------------------------
  // Channel state mirror: registers, counters and flags as the block keeps them
  // --------------------------------------------------------------------------
  logic [7:0]  m_sweep, m_len_duty, m_env, m_per_lo, m_per_hi;
  logic        m_active, m_sweep_en;
  logic [13:0] m_timer;
  logic [10:0] m_period, m_shadow;
  logic [6:0]  m_len_cnt;
  logic [2:0]  m_env_cnt, m_duty_pos;
  logic [3:0]  m_volume, m_sweep_cnt;

  chan_word_t results_pending[$];
  int         fail_count;
  int         idle_cycles;
  int         words_counted;
  logic       steady_flow;

  // Drop every piece of channel state back to zero (reset and the clear op).
  function automatic void clear_channel();
    m_sweep = '0; m_len_duty = '0; m_env = '0; m_per_lo = '0; m_per_hi = '0;
    m_active = 1'b0; m_sweep_en = 1'b0;
    m_timer = '0; m_period = '0; m_shadow = '0;
    m_len_cnt = '0; m_env_cnt = '0; m_volume = '0; m_sweep_cnt = '0; m_duty_pos = '0;
  endfunction

  function automatic logic [13:0] reload_of(input logic [10:0] p);
    return 14'((2048 - int'(p)) * 4);
  endfunction

  // One sweep calculation; a result past 2047 silences the channel.
  function automatic logic [11:0] swept_period();
    logic [11:0] delta;
    logic [11:0] nxt;
    delta = {1'b0, m_shadow} >> m_sweep[2:0];
    nxt   = m_sweep[3] ? ({1'b0, m_shadow} - delta) : ({1'b0, m_shadow} + delta);
    if (nxt > 12'd2047) m_active = 1'b0;
    return nxt;
  endfunction

  // Trigger: reload the counters (length only if empty) and arm the sweep, with no overflow check.
  function automatic void trigger_channel();
    logic [2:0] pace;
    pace = m_sweep[6:4];
    if (m_env[7:3] != 5'd0) m_active = 1'b1;
    if (m_len_cnt == 7'd0) m_len_cnt = sqwsw_pkg::LEN_FULL;
    m_env_cnt   = m_env[2:0];
    m_volume    = m_env[7:4];
    m_period    = {m_per_hi[2:0], m_per_lo};
    m_shadow    = m_period;
    m_sweep_cnt = (pace == 3'd0) ? 4'd8 : {1'b0, pace};
    m_sweep_en  = (pace != 3'd0) || (m_sweep[2:0] != 3'd0);
    m_timer     = reload_of(m_period);
  endfunction

  function automatic void sweep_tick();
    logic [2:0]  pace;
    logic [11:0] nxt;
    if (m_sweep_cnt == 4'd0) return;
    m_sweep_cnt = m_sweep_cnt - 4'd1;
    if (m_sweep_cnt != 4'd0) return;
    pace        = m_sweep[6:4];
    m_sweep_cnt = (pace == 3'd0) ? 4'd8 : {1'b0, pace};
    if (m_sweep_en && pace != 3'd0) begin
      nxt = swept_period();
      if (nxt <= 12'd2047 && m_sweep[2:0] != 3'd0) begin
        m_shadow = nxt[10:0];
        m_period = nxt[10:0];
        // second pass only for its overflow side effect
        void'(swept_period());
      end
    end
  endfunction

  function automatic void envelope_tick();
    if (m_env[2:0] == 3'd0 || m_env_cnt == 3'd0) return;
    m_env_cnt = m_env_cnt - 3'd1;
    if (m_env_cnt == 3'd0) begin
      m_env_cnt = m_env[2:0];
      if (m_env[3]) begin
        if (m_volume != 4'd15) m_volume = m_volume + 4'd1;
      end else begin
        if (m_volume != 4'd0) m_volume = m_volume - 4'd1;
      end
    end
  endfunction

  // Apply one accepted input word to the mirror and return the word the
  // block must answer with.
  function automatic chan_word_t apply_word(input sqwsw_pkg::func_t f,
                                            input logic [15:0] a,
                                            input logic [7:0] d);
    chan_word_t r;
    r.read_data = sqwsw_pkg::READ_IDLE;
    r.sample    = 4'd0;
    case (f)
      sqwsw_pkg::FUNC_READ: begin
        case (a)
          sqwsw_pkg::ADDR_SWEEP:   r.read_data = m_sweep | 8'h80;
          sqwsw_pkg::ADDR_LEN_DTY: r.read_data = m_len_duty | 8'h3F;
          sqwsw_pkg::ADDR_ENV:     r.read_data = m_env;
          sqwsw_pkg::ADDR_PER_HI:  r.read_data = m_per_hi | 8'hBF;
          default:                 r.read_data = sqwsw_pkg::READ_IDLE;
        endcase
      end
      sqwsw_pkg::FUNC_WRITE: begin
        case (a)
          sqwsw_pkg::ADDR_SWEEP: m_sweep = d;
          sqwsw_pkg::ADDR_LEN_DTY: begin
            m_len_duty = d;
            m_len_cnt  = sqwsw_pkg::LEN_FULL - {1'b0, d[5:0]};
          end
          sqwsw_pkg::ADDR_ENV: begin
            m_env = d;
            if (d[7:3] == 5'd0) m_active = 1'b0;
          end
          sqwsw_pkg::ADDR_PER_LO: m_per_lo = d;
          sqwsw_pkg::ADDR_PER_HI: begin
            m_per_hi = d;
            if (d[7]) trigger_channel();
          end
          default: ;
        endcase
      end
      sqwsw_pkg::FUNC_TIMER: begin
        if (m_timer != 14'd0) begin
          m_timer = m_timer - 14'd1;
          if (m_timer == 14'd0) begin
            m_timer    = reload_of(m_period);
            m_duty_pos = m_duty_pos + 3'd1;
          end
        end
      end
      sqwsw_pkg::FUNC_LENGTH: begin
        if (m_per_hi[6] && m_len_cnt != 7'd0) begin
          m_len_cnt = m_len_cnt - 7'd1;
          if (m_len_cnt == 7'd0) m_active = 1'b0;
        end
      end
      sqwsw_pkg::FUNC_ENVELOPE: envelope_tick();
      sqwsw_pkg::FUNC_SWEEP:    sweep_tick();
      sqwsw_pkg::FUNC_CLEAR:    clear_channel();
      default: ;
    endcase
    if (m_active && m_env[7:3] != 5'd0 && DUTY_WAVES[m_len_duty[7:6]][3'd7 - m_duty_pos])
      r.sample = m_volume;
    r.channel_on = m_active;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, result sink and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap length: short in most draws, medium in a quarter of them, long in one draw in twenty.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result side at random; hold ready high while steady_flow is set.
  initial begin : result_sink
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady_flow && $urandom_range(0, 99) < 15) hold = idle_len();
      end
    end
  end

  // Score every handshake on both channels. The input side is taken first so
  // the expectation exists whatever the block's latency is.
  always @(posedge clk) begin
    chan_word_t want;
    chan_word_t got;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        results_pending.push_back(apply_word(in_ch.func, in_ch.address, in_ch.write_data));
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        got.read_data  = out_ch.read_data;
        got.sample     = out_ch.sample;
        got.channel_on = out_ch.channel_on;
        if (results_pending.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected word: rd=%02h smp=%0d on=%0b", $realtime,
                     got.read_data, got.sample, got.channel_on);
        end else begin
          want = results_pending.pop_front();
          if (want.read_data !== got.read_data || want.sample !== got.sample ||
              want.channel_on !== got.channel_on) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] mismatch: exp rd=%02h smp=%0d on=%0b, %s",
                       $realtime, want.read_data, want.sample, want.channel_on,
                       $sformatf("got rd=%02h smp=%0d on=%0b",
                                 got.read_data, got.sample, got.channel_on));
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // Bail out when traffic stops for far longer than any legal stall.
  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Drive one word and wait for it to be taken. Valid stays high on return so
  // back-to-back words need no drop; the next call lowers it only for a gap.
  task automatic send_word(input sqwsw_pkg::func_t f, input logic [15:0] a,
                           input logic [7:0] d);
    int gap;
    gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.address    <= a;
    in_ch.write_data <= d;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    // ignored words do not advance the count
    if (!(f == FUNC_UNUSED ||
          (f == sqwsw_pkg::FUNC_WRITE &&
           (a < sqwsw_pkg::ADDR_SWEEP || a > sqwsw_pkg::ADDR_PER_HI))))
      words_counted++;
  endtask

  task automatic write_reg(input logic [15:0] a, input logic [7:0] d);
    send_word(sqwsw_pkg::FUNC_WRITE, a, d);
  endtask

  // Hold the sender until every expected word is back, then let the bench settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (results_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register map: extremes, unused bits, the write-only period low byte,
  // accesses off the map and the unused func code.
  task automatic test_register_map();
    send_word(sqwsw_pkg::FUNC_TIMER, 16'h0000, 8'h00);   // timer still at zero: no change
    send_word(FUNC_UNUSED, 16'hFFFF, 8'hFF);
    write_reg(sqwsw_pkg::ADDR_SWEEP, 8'h7F);
    write_reg(sqwsw_pkg::ADDR_LEN_DTY, 8'hFF);
    write_reg(sqwsw_pkg::ADDR_ENV, 8'hFF);
    write_reg(sqwsw_pkg::ADDR_PER_LO, 8'hFF);
    write_reg(sqwsw_pkg::ADDR_PER_HI, 8'h7F);            // all but the trigger bit
    for (int i = 0; i < 5; i++)
      send_word(sqwsw_pkg::FUNC_READ, sqwsw_pkg::ADDR_SWEEP + 16'(i), 8'h00);
    send_word(sqwsw_pkg::FUNC_READ, 16'h0000, 8'h00);
    write_reg(16'hFF15, 8'h00);               // just past the map: ignored
    write_reg(16'hFF0F, 8'h00);
    send_word(sqwsw_pkg::FUNC_CLEAR, 16'h0000, 8'h00);
    send_word(sqwsw_pkg::FUNC_READ, sqwsw_pkg::ADDR_SWEEP, 8'h00);
    drain_results();
  endtask

  // Trigger at the top period so the duty step advances every four ticks.
  task automatic test_duty_timer();
    write_reg(sqwsw_pkg::ADDR_ENV, 8'hF0);
    write_reg(sqwsw_pkg::ADDR_LEN_DTY, 8'hC0);
    write_reg(sqwsw_pkg::ADDR_PER_LO, 8'hFF);
    write_reg(sqwsw_pkg::ADDR_PER_HI, 8'h87);
    repeat (9) send_word(sqwsw_pkg::FUNC_TIMER, 16'h0000, 8'h00);
    drain_results();
  endtask

  // Length of one with the length enable set: one tick turns the channel off.
  task automatic test_length_expiry();
    write_reg(sqwsw_pkg::ADDR_LEN_DTY, 8'hFF);
    write_reg(sqwsw_pkg::ADDR_PER_HI, 8'hC7);
    send_word(sqwsw_pkg::FUNC_LENGTH, 16'h0000, 8'h00);
    drain_results();
  endtask

  // Envelope holds at 15 going up and at 0 going down; a DAC-off write kills it.
  task automatic test_envelope_limits();
    write_reg(sqwsw_pkg::ADDR_ENV, 8'hF9);
    write_reg(sqwsw_pkg::ADDR_PER_HI, 8'h87);
    send_word(sqwsw_pkg::FUNC_ENVELOPE, 16'h0000, 8'h00);
    write_reg(sqwsw_pkg::ADDR_ENV, 8'h11);
    write_reg(sqwsw_pkg::ADDR_PER_HI, 8'h87);
    send_word(sqwsw_pkg::FUNC_ENVELOPE, 16'h0000, 8'h00);
    send_word(sqwsw_pkg::FUNC_ENVELOPE, 16'h0000, 8'h00);
    write_reg(sqwsw_pkg::ADDR_ENV, 8'h07);
    drain_results();
  endtask

  // Upward sweep from period 2047 overflows on the first sweep tick.
  task automatic test_sweep_overflow();
    write_reg(sqwsw_pkg::ADDR_ENV, 8'hF0);
    write_reg(sqwsw_pkg::ADDR_SWEEP, 8'h11);
    write_reg(sqwsw_pkg::ADDR_PER_HI, 8'h87);
    send_word(sqwsw_pkg::FUNC_SWEEP, 16'h0000, 8'h00);
    drain_results();
  endtask

  // Set up a channel with random content, biased toward short periods and
  // lengths so that duty steps, expiry and sweep all show up within a burst.
  task automatic program_channel();
    logic [7:0] len_byte, env_byte, lo_byte, hi_byte;
    len_byte = 8'($urandom);
    if ($urandom_range(0, 2) != 0) len_byte[5:4] = 2'b11;
    env_byte = 8'($urandom);
    if ($urandom_range(0, 9) == 0) env_byte[7:3] = 5'd0;
    lo_byte = 8'($urandom);
    if ($urandom_range(0, 3) != 0) lo_byte[7:3] = 5'b11111;
    hi_byte = 8'($urandom);
    hi_byte[7] = 1'b1;
    if ($urandom_range(0, 3) != 0) hi_byte[2:0] = 3'b111;
    if ($urandom_range(0, 3) != 0) write_reg(sqwsw_pkg::ADDR_SWEEP, 8'($urandom));
    write_reg(sqwsw_pkg::ADDR_LEN_DTY, len_byte);
    write_reg(sqwsw_pkg::ADDR_ENV, env_byte);
    write_reg(sqwsw_pkg::ADDR_PER_LO, lo_byte);
    write_reg(sqwsw_pkg::ADDR_PER_HI, hi_byte);
  endtask

  // Run the programmed channel: mostly timer ticks, with the frame-sequencer
  // ticks, reads and the odd register rewrite mixed in.
  task automatic run_tick_burst(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_word(sqwsw_pkg::FUNC_TIMER, 16'($urandom), 8'($urandom));
      else if (pick < 57)
        send_word(sqwsw_pkg::FUNC_LENGTH, 16'($urandom), 8'($urandom));
      else if (pick < 72)
        send_word(sqwsw_pkg::FUNC_ENVELOPE, 16'($urandom), 8'($urandom));
      else if (pick < 87)
        send_word(sqwsw_pkg::FUNC_SWEEP, 16'($urandom), 8'($urandom));
      else if (pick < 97)
        send_word(sqwsw_pkg::FUNC_READ,
                  sqwsw_pkg::ADDR_SWEEP + 16'($urandom_range(0, 4)), 8'($urandom));
      else
        write_reg(sqwsw_pkg::ADDR_SWEEP + 16'($urandom_range(0, 4)), 8'($urandom));
    end
  endtask

  // Any func code, any address, any byte.
  task automatic send_noise(input int n);
    logic [15:0] a;
    for (int i = 0; i < n; i++) begin
      a = ($urandom_range(0, 1) == 0)
            ? 16'($urandom)
            : sqwsw_pkg::ADDR_SWEEP - 16'd2 + 16'($urandom_range(0, 6));
      send_word(sqwsw_pkg::func_t'($urandom_range(0, 7)), a, 8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int  goal;
    bit  paused;
    goal   = words_counted + RANDOM_WORDS;
    paused = 1'b0;
    while (words_counted < goal) begin
      // run some stretches with no idling on either side
      steady_flow = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) begin
        program_channel();
        run_tick_burst($urandom_range(10, 60));
      end else begin
        send_noise($urandom_range(3, 15));
      end
      // stop feeding once midway until the result side has caught up
      if (!paused && words_counted >= goal - RANDOM_WORDS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    steady_flow = 1'b0;
    drain_results();
  endtask

  initial begin
    fail_count    = 0;
    idle_cycles   = 0;
    words_counted = 0;
    steady_flow   = 1'b0;
    clear_channel();
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= sqwsw_pkg::FUNC_READ;
    in_ch.address    <= '0;
    in_ch.write_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_register_map();
    test_duty_timer();
    test_length_expiry();
    test_envelope_limits();
    test_sweep_overflow();
    test_random_traffic();

    // watch a little longer for stray words
    repeat (10) @(posedge clk);
    if (fail_count == 0 && results_pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
